// ----- sv/pwl_pkg.sv -----
// ============================================================================
// pwl_pkg - shared types and constants of the piecewise-linear lookup core
// Table depth, index widths, register and source codes, and the command and
// status bundles that pass between the controller and the datapath.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package pwl_pkg;

    // table geometry
    localparam int MAX_POINTS = 128;
    localparam int IDX_W      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int CMP_W      = (CNT_W > 8) ? CNT_W : 8;

    // field widths
    localparam int DATA_W     = 32;
    localparam int SLOT_W     = 7;
    localparam int COUNT_W    = 8;
    localparam int SRC_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int IN_DATA_W  = 104;
    localparam int OUT_DATA_W = 64;

    // divider
    localparam int DIV_STEPS  = DATA_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEF_X  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEF_Y  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POINTS = 2'd2;

    localparam logic [DATA_W-1:0] DEF_COND_RESET = 32'h0001_0000;

    // opcodes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // result source codes
    localparam logic [SRC_W-1:0] SRC_DEFAULT = 2'd0;
    localparam logic [SRC_W-1:0] SRC_CLAMP   = 2'd1;
    localparam logic [SRC_W-1:0] SRC_INTERP  = 2'd2;

    // read address select
    localparam logic [1:0] RD_ZERO = 2'd0;
    localparam logic [1:0] RD_LAST = 2'd1;
    localparam logic [1:0] RD_NEXT = 2'd2;

    // result select
    localparam logic [1:0] RES_DEFAULT = 2'd0;
    localparam logic [1:0] RES_ENTRY   = 2'd1;
    localparam logic [1:0] RES_LEFT    = 2'd2;
    localparam logic [1:0] RES_INTERP  = 2'd3;

    typedef struct packed {
        logic       load_we;
        logic       cap_query;
        logic [1:0] rd_sel;
        logic       idx_clr;
        logic       idx_inc;
        logic       set_prev;
        logic       seg_latch;
        logic       diff_en;
        logic       mul_en;
        logic       div_init;
        logic       div_step;
        logic       res_we;
        logic [1:0] res_sel;
        logic       out_push;
    } t_ctl_cmd;

    typedef struct packed {
        logic n_zero;
        logic n_one;
        logic t_le_rd;
        logic t_ge_rd;
        logic seg_hit;
        logic idx_last;
        logic span_zero;
        logic div_last;
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

// ----- sv/pwl_ctrl.sv -----
// ============================================================================
// pwl_ctrl - sequencing state machine
// Takes loads and steps a query through the end-point checks, the segment scan,
// the multiply and the bit-serial divide, and hands the result to the output.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module pwl_ctrl
    import pwl_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic       i_opcode,
    output logic            o_in_ready,
    input  wire t_dp_status i_status,
    output t_ctl_cmd        o_cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_START = 4'd1;
    localparam logic [3:0] S_CHK0  = 4'd2;
    localparam logic [3:0] S_CHKL  = 4'd3;
    localparam logic [3:0] S_SCAN  = 4'd4;
    localparam logic [3:0] S_DIFF  = 4'd5;
    localparam logic [3:0] S_MUL   = 4'd6;
    localparam logic [3:0] S_DIVI  = 4'd7;
    localparam logic [3:0] S_DIV   = 4'd8;
    localparam logic [3:0] S_FIN   = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       w_accept;

    assign o_in_ready = i_rst_n && (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_opcode == OP_LOAD) begin
                        o_cmd.load_we = 1'b1;
                    end else begin
                        o_cmd.cap_query = 1'b1;
                        n_state = S_START;
                    end
                end
            end
            S_START: begin
                if (i_status.n_zero) begin
                    o_cmd.res_we  = 1'b1;
                    o_cmd.res_sel = RES_DEFAULT;
                    n_state = S_OUT;
                end else begin
                    o_cmd.rd_sel = RD_ZERO;
                    n_state = S_CHK0;
                end
            end
            S_CHK0: begin
                o_cmd.set_prev = 1'b1;
                o_cmd.idx_clr  = 1'b1;
                if (i_status.n_one || i_status.t_le_rd) begin
                    o_cmd.res_we  = 1'b1;
                    o_cmd.res_sel = RES_ENTRY;
                    n_state = S_OUT;
                end else begin
                    o_cmd.rd_sel = RD_LAST;
                    n_state = S_CHKL;
                end
            end
            S_CHKL: begin
                if (i_status.t_ge_rd) begin
                    o_cmd.res_we  = 1'b1;
                    o_cmd.res_sel = RES_ENTRY;
                    n_state = S_OUT;
                end else begin
                    // fetch entry one, first right edge of the scan
                    o_cmd.rd_sel  = RD_NEXT;
                    o_cmd.idx_inc = 1'b1;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_status.seg_hit) begin
                    o_cmd.seg_latch = 1'b1;
                    n_state = S_DIFF;
                end else if (i_status.idx_last) begin
                    o_cmd.res_we  = 1'b1;
                    o_cmd.res_sel = RES_DEFAULT;
                    n_state = S_OUT;
                end else begin
                    o_cmd.set_prev = 1'b1;
                    o_cmd.rd_sel   = RD_NEXT;
                    o_cmd.idx_inc  = 1'b1;
                end
            end
            S_DIFF: begin
                o_cmd.diff_en = 1'b1;
                n_state = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul_en = 1'b1;
                if (i_status.span_zero) begin
                    o_cmd.res_we  = 1'b1;
                    o_cmd.res_sel = RES_LEFT;
                    n_state = S_OUT;
                end else begin
                    n_state = S_DIVI;
                end
            end
            S_DIVI: begin
                o_cmd.div_init = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.res_we  = 1'b1;
                o_cmd.res_sel = RES_INTERP;
                n_state = S_OUT;
            end
            S_OUT: begin
                // hold until the output register can take the result
                if (i_status.out_free) begin
                    o_cmd.out_push = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- sv/pwl_datapath.sv -----
// ============================================================================
// pwl_datapath - breakpoint table, scan registers, multiplier and divider
// Holds the configuration registers, the breakpoint memory with registered
// read, the segment arithmetic and the output register.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module pwl_datapath
    import pwl_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [DATA_W-1:0]    i_cfg_data,
    input  wire logic [SLOT_W-1:0]    i_point_index,
    input  wire logic [DATA_W-1:0]    i_point_temperature,
    input  wire logic [DATA_W-1:0]    i_point_conductivity,
    input  wire logic [DATA_W-1:0]    i_query_temperature,
    input  wire t_ctl_cmd             i_cmd,
    output t_dp_status                o_status,
    input  wire logic                 i_out_ready,
    output logic                      o_out_valid,
    output logic [DATA_W-1:0]         o_cond_x,
    output logic [DATA_W-1:0]         o_cond_y,
    output logic [SRC_W-1:0]          o_result_source
);

    // configuration
    logic [DATA_W-1:0]  r_def_x;
    logic [DATA_W-1:0]  r_def_y;
    logic [COUNT_W-1:0] r_points;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_def_x  <= DEF_COND_RESET;
            r_def_y  <= DEF_COND_RESET;
            r_points <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DEF_X:  r_def_x  <= i_cfg_data;
                CFG_DEF_Y:  r_def_y  <= i_cfg_data;
                CFG_POINTS: r_points <= i_cfg_data[COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // effective count, clamped to the table depth
    logic [CMP_W-1:0] w_points_wide;
    logic [CNT_W-1:0] w_n;
    logic [IDX_W-1:0] w_last;

    assign w_points_wide = CMP_W'(r_points);
    assign w_n    = (w_points_wide > CMP_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS)
                                                         : CNT_W'(w_points_wide);
    assign w_last = IDX_W'(w_n - CNT_W'(1));

    // breakpoint memory
    logic [DATA_W-1:0] r_mem_t [MAX_POINTS];
    logic [DATA_W-1:0] r_mem_c [MAX_POINTS];
    logic              w_slot_ok;
    logic [IDX_W-1:0]  w_wr_addr;
    logic [IDX_W-1:0]  w_rd_addr;
    logic [IDX_W-1:0]  r_idx;
    logic signed [DATA_W-1:0] r_rd_t;
    logic signed [DATA_W-1:0] r_rd_c;

    assign w_slot_ok = (32'(i_point_index) < MAX_POINTS);
    assign w_wr_addr = IDX_W'(i_point_index);

    always_comb begin
        case (i_cmd.rd_sel)
            RD_ZERO: w_rd_addr = '0;
            RD_LAST: w_rd_addr = w_last;
            RD_NEXT: w_rd_addr = r_idx + IDX_W'(1);
            default: w_rd_addr = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_we && w_slot_ok) begin
            r_mem_t[w_wr_addr] <= i_point_temperature;
            r_mem_c[w_wr_addr] <= i_point_conductivity;
        end
        r_rd_t <= r_mem_t[w_rd_addr];
        r_rd_c <= r_mem_c[w_rd_addr];
    end

    // scan registers
    logic signed [DATA_W-1:0] r_q_t;
    logic signed [DATA_W-1:0] r_prev_t;
    logic signed [DATA_W-1:0] r_prev_c;
    logic signed [DATA_W-1:0] r_ti;
    logic signed [DATA_W-1:0] r_ci;
    logic signed [DATA_W-1:0] r_tj;
    logic signed [DATA_W-1:0] r_cj;

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_query) begin
            r_q_t <= i_query_temperature;
        end
        if (i_cmd.idx_clr) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + IDX_W'(1);
        end
        if (i_cmd.set_prev) begin
            r_prev_t <= r_rd_t;
            r_prev_c <= r_rd_c;
        end
        if (i_cmd.seg_latch) begin
            r_ti <= r_prev_t;
            r_ci <= r_prev_c;
            r_tj <= r_rd_t;
            r_cj <= r_rd_c;
        end
    end

    // segment differences; all fit 32 bits unsigned once the sign is split off
    logic signed [DATA_W:0] w_dc;
    logic        [DATA_W:0] w_mag;
    logic        [DATA_W:0] w_off;
    logic        [DATA_W:0] w_span;
    logic [DATA_W-1:0]      r_mag;
    logic [DATA_W-1:0]      r_off;
    logic [DATA_W-1:0]      r_span;
    logic                   r_neg;

    assign w_dc   = {r_cj[DATA_W-1], r_cj} - {r_ci[DATA_W-1], r_ci};
    assign w_mag  = w_dc[DATA_W] ? (~w_dc + 1'b1) : w_dc;
    assign w_off  = {r_q_t[DATA_W-1], r_q_t} - {r_ti[DATA_W-1], r_ti};
    assign w_span = {r_tj[DATA_W-1], r_tj} - {r_ti[DATA_W-1], r_ti};

    logic [2*DATA_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_cmd.diff_en) begin
            r_mag  <= w_mag[DATA_W-1:0];
            r_off  <= w_off[DATA_W-1:0];
            r_span <= w_span[DATA_W-1:0];
            r_neg  <= w_dc[DATA_W];
        end
        if (i_cmd.mul_en) begin
            r_prod <= r_mag * r_off;
        end
    end

    // restoring divide, one quotient bit per cycle; the high half of the
    // product is already below the span, so the quotient fits 32 bits
    logic [DATA_W-1:0]    r_rem;
    logic [DATA_W-1:0]    r_quo;
    logic [DIV_CNT_W-1:0] r_div_cnt;
    logic [DATA_W:0]      w_rem2;
    logic [DATA_W:0]      w_rem_sub;
    logic                 w_qbit;

    assign w_rem2    = {r_rem, r_quo[DATA_W-1]};
    assign w_rem_sub = w_rem2 - {1'b0, r_span};
    assign w_qbit    = (w_rem2 >= {1'b0, r_span});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_cnt <= '0;
        end else if (i_cmd.div_init) begin
            r_div_cnt <= DIV_CNT_W'(DIV_STEPS);
        end else if (i_cmd.div_step) begin
            r_div_cnt <= r_div_cnt - DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_rem <= r_prod[2*DATA_W-1:DATA_W];
            r_quo <= r_prod[DATA_W-1:0];
        end else if (i_cmd.div_step) begin
            r_rem <= w_qbit ? w_rem_sub[DATA_W-1:0] : w_rem2[DATA_W-1:0];
            r_quo <= {r_quo[DATA_W-2:0], w_qbit};
        end
    end

    // result staging
    logic [DATA_W-1:0] r_res_x;
    logic [DATA_W-1:0] r_res_y;
    logic [SRC_W-1:0]  r_res_src;
    logic [DATA_W-1:0] w_interp;

    assign w_interp = r_neg ? (r_ci - r_quo) : (r_ci + r_quo);

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_we) begin
            case (i_cmd.res_sel)
                RES_DEFAULT: begin
                    r_res_x   <= r_def_x;
                    r_res_y   <= r_def_y;
                    r_res_src <= SRC_DEFAULT;
                end
                RES_ENTRY: begin
                    r_res_x   <= r_rd_c;
                    r_res_y   <= r_rd_c;
                    r_res_src <= SRC_CLAMP;
                end
                RES_LEFT: begin
                    r_res_x   <= r_ci;
                    r_res_y   <= r_ci;
                    r_res_src <= SRC_INTERP;
                end
                RES_INTERP: begin
                    r_res_x   <= w_interp;
                    r_res_y   <= w_interp;
                    r_res_src <= SRC_INTERP;
                end
                default: begin
                    r_res_x   <= r_def_x;
                    r_res_y   <= r_def_y;
                    r_res_src <= SRC_DEFAULT;
                end
            endcase
        end
    end

    // output register
    logic r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_push) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_push) begin
            o_cond_x        <= r_res_x;
            o_cond_y        <= r_res_y;
            o_result_source <= r_res_src;
        end
    end

    assign o_out_valid = r_out_valid;

    // status back to the controller
    assign o_status.n_zero    = (w_n == '0);
    assign o_status.n_one     = (w_n == CNT_W'(1));
    assign o_status.t_le_rd   = (r_q_t <= r_rd_t);
    assign o_status.t_ge_rd   = (r_q_t >= r_rd_t);
    assign o_status.seg_hit   = (r_q_t >= r_prev_t) && (r_q_t <= r_rd_t);
    assign o_status.idx_last  = (r_idx == w_last);
    assign o_status.span_zero = (r_span == '0);
    assign o_status.div_last  = (r_div_cnt == DIV_CNT_W'(1));
    assign o_status.out_free  = !r_out_valid || i_out_ready;

endmodule

`default_nettype wire

// ----- sv/piecewise_linear_table_interp_core.sv -----
// ============================================================================
// piecewise_linear_table_interp_core - clamped piecewise-linear lookup
// Breakpoint table of temperature/conductivity pairs in Q16.16 with a
// clamped, linearly interpolated query.
// ============================================================================
//
//  channel   dir  handshake                     content
//  s_axis    in   s_axis_tvalid/s_axis_tready  load or query transaction
//  m_axis    out  m_axis_tvalid/m_axis_tready  conductivity result
//  cfg       in   i_cfg_valid/o_cfg_ready      register write (index, data)
//
//  A load transaction gives no result. A query that is clamped to an end
//  point or finds an empty table is answered before the segment scan; an
//  interpolated query reads one table entry a cycle during the segment
//  scan, then runs the one-bit-per-cycle divider.
//  Synchronous active-low reset holds both input channels not ready; the
//  table is not cleared.
//  A stalled result waits in the output register; the next transaction is
//  taken meanwhile and its result holds until that register frees.
//
`timescale 1ns / 1ps
`default_nettype none

module piecewise_linear_table_interp_core
    import pwl_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // cfg
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [DATA_W-1:0]     i_cfg_data,
    // s_axis
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // point_index[6:0], point_temperature[38:7], point_conductivity[70:39],
    // query_temperature[102:71], zero pad [103]
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // opcode[0]
    input  wire logic                  s_axis_tuser,
    // m_axis
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // cond_x[31:0], cond_y[63:32]
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    // result_source[1:0]
    output logic [SRC_W-1:0]           m_axis_tuser
);

    t_ctl_cmd   w_cmd;
    t_dp_status w_status;
    logic [DATA_W-1:0] w_cond_x;
    logic [DATA_W-1:0] w_cond_y;

    assign o_cfg_ready  = i_rst_n;
    assign m_axis_tdata = {w_cond_y, w_cond_x};

    pwl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_opcode   (s_axis_tuser),
        .o_in_ready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    pwl_datapath u_datapath (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg_valid && o_cfg_ready),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data),
        .i_point_index        (s_axis_tdata[6:0]),
        .i_point_temperature  (s_axis_tdata[38:7]),
        .i_point_conductivity (s_axis_tdata[70:39]),
        .i_query_temperature  (s_axis_tdata[102:71]),
        .i_cmd                (w_cmd),
        .o_status             (w_status),
        .i_out_ready          (m_axis_tready),
        .o_out_valid          (m_axis_tvalid),
        .o_cond_x             (w_cond_x),
        .o_cond_y             (w_cond_y),
        .o_result_source      (m_axis_tuser)
    );

endmodule

`default_nettype wire

// ----- sv/pwl_checker.sv -----
// ============================================================================
// pwl_checker - port-level checks of the lookup core
// Watches the result channel for reset behavior, legal source codes, the
// matched x/y answer and a held stalled transaction.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module pwl_checker
    import pwl_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  m_axis_tvalid,
    input wire logic                  m_axis_tready,
    input wire logic [OUT_DATA_W-1:0] m_axis_tdata,
    input wire logic [SRC_W-1:0]      m_axis_tuser
);

    // no result survives a reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_src_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser == SRC_DEFAULT || m_axis_tuser == SRC_CLAMP ||
                           m_axis_tuser == SRC_INTERP))
        else $error("illegal result source");

    // only the default pair may differ between axes
    a_xy_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != SRC_DEFAULT)
            |-> (m_axis_tdata[31:0] == m_axis_tdata[63:32]))
        else $error("x and y answers differ on a table result");

    a_hold_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready)
            |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind piecewise_linear_table_interp_core pwl_checker u_pwl_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
